/* sv/rps_pkg.sv */
// Shared types and constants for the routing parent selector.
// No dependencies; used by every module of the block.
package rps_pkg;

    localparam int ETX_UNIT_DEF = 128;
    localparam int TERM_FULL    = 1000;
    localparam int TERM_W       = 10;
    localparam int SCORE_W      = 12;
    localparam int COST_W       = 16;
    localparam int AGE_NUM_W    = 18;
    localparam int DIV_STAGES   = 3;
    localparam int RSSI_LOW     = -100;
    localparam int RSSI_HIGH    = -30;
    localparam logic [15:0] NO_STATS = 16'hFFFF;
    localparam logic [15:0] COST_CAP = 16'hFFFF;
    // (x * 1000 / 70) == (x * SIG_RECIP) >> 16 for x in 1..69
    localparam logic [19:0] SIG_RECIP = 20'd936229;
    // floor(s / 1000) is (s * DIV1K_RECIP) >> 22 or one less
    localparam logic [12:0] DIV1K_RECIP = 13'd4194;

    localparam int CFG_AW = 5;
    typedef enum logic [2:0] {
        REG_WEIGHT_SIGNAL = 3'd0,
        REG_WEIGHT_LINK   = 3'd1,
        REG_WEIGHT_MATURE = 3'd2,
        REG_AGE_FULL      = 3'd3,
        REG_SWITCH_MARGIN = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        PICK_NONE   = 2'd0,
        PICK_FIRST  = 2'd1,
        PICK_SECOND = 2'd2
    } pick_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic [1:0]  preferred;
        logic [15:0] second_rank;
        logic [15:0] second_age;
        logic [15:0] second_etx;
        logic signed [7:0] second_rssi;
        logic        second_present;
        logic [15:0] first_rank;
        logic [15:0] first_age;
        logic [15:0] first_etx;
        logic signed [7:0] first_rssi;
        logic        first_present;
    } in_beat_t;

    typedef struct packed {
        logic [5:0]         pad;
        logic [SCORE_W-1:0] second_score;
        logic [SCORE_W-1:0] first_score;
        logic [1:0]         chosen;
    } out_beat_t;

    typedef struct packed {
        logic              ok1;
        logic              ok2;
        logic [1:0]        pref;
        logic [COST_W-1:0] cost1;
        logic [COST_W-1:0] cost2;
        logic [TERM_W-1:0] sig1;
        logic [TERM_W-1:0] sig2;
        logic              full1;
        logic              full2;
    } side_t;

    typedef struct packed {
        logic [15:0]          etx1;
        logic [15:0]          etx2;
        logic [AGE_NUM_W-1:0] num1;
        logic [AGE_NUM_W-1:0] num2;
    } divop_t;

endpackage

/* sv/rps_front.sv */
// Input stage: acceptability, path cost, signal term and divider operands.
// Depends on rps_pkg.
module rps_front #(
    parameter int ETX_UNIT = rps_pkg::ETX_UNIT_DEF
) (
    input  logic              aclk,
    input  logic              en,
    input  rps_pkg::in_beat_t beat,
    input  logic [7:0]        age_full,
    output rps_pkg::side_t    side_reg,
    output rps_pkg::divop_t   divop_reg
);

    localparam logic [15:0] UNIT = 16'(ETX_UNIT);

    rps_pkg::side_t  side_next;
    rps_pkg::divop_t divop_next;

    function automatic logic [16:0] cost_of(input logic [15:0] rank, input logic [15:0] etx);
        logic [16:0] sum;
        sum = {1'b0, rank} + {1'b0, etx};
        return sum[16] ? {1'b0, rps_pkg::COST_CAP} : sum;
    endfunction

    function automatic logic [9:0] sig_of(input logic signed [7:0] rssi);
        logic [6:0]  x;
        logic [26:0] prod;
        logic [9:0]  res;
        x    = 7'(rssi + 8'sd100);
        prod = 27'(x) * 27'(rps_pkg::SIG_RECIP);
        if (rssi <= 8'(rps_pkg::RSSI_LOW)) begin
            res = '0;
        end else if (rssi >= 8'(rps_pkg::RSSI_HIGH)) begin
            res = 10'(rps_pkg::TERM_FULL);
        end else begin
            res = prod[25:16];
        end
        return res;
    endfunction

    function automatic logic age_full_of(input logic [15:0] age, input logic [7:0] afs);
        return (afs == '0) || (age >= {8'd0, afs});
    endfunction

    always_comb begin
        logic [16:0] c1;
        logic [16:0] c2;
        c1 = cost_of(beat.first_rank, beat.first_etx);
        c2 = cost_of(beat.second_rank, beat.second_etx);
        side_next.ok1   = beat.first_present && (beat.first_etx != rps_pkg::NO_STATS)
                          && (c1[15:0] != rps_pkg::COST_CAP);
        side_next.ok2   = beat.second_present && (beat.second_etx != rps_pkg::NO_STATS)
                          && (c2[15:0] != rps_pkg::COST_CAP);
        side_next.pref  = beat.preferred;
        side_next.cost1 = c1[15:0];
        side_next.cost2 = c2[15:0];
        side_next.sig1  = sig_of(beat.first_rssi);
        side_next.sig2  = sig_of(beat.second_rssi);
        side_next.full1 = age_full_of(beat.first_age, age_full);
        side_next.full2 = age_full_of(beat.second_age, age_full);
        divop_next.etx1 = (beat.first_etx < UNIT) ? UNIT : beat.first_etx;
        divop_next.etx2 = (beat.second_etx < UNIT) ? UNIT : beat.second_etx;
        divop_next.num1 = side_next.full1 ? '0
                          : 18'(beat.first_age[7:0]) * 18'(rps_pkg::TERM_FULL);
        divop_next.num2 = side_next.full2 ? '0
                          : 18'(beat.second_age[7:0]) * 18'(rps_pkg::TERM_FULL);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg  <= side_next;
            divop_reg <= divop_next;
        end
    end

endmodule

/* sv/rps_div.sv */
// Pipelined restoring divider, quotient bits spread over NS register stages.
// Depends on rps_pkg; dividend must be below divisor << QW.
module rps_div #(
    parameter int DW = 20,
    parameter int VW = 16,
    parameter int QW = rps_pkg::TERM_W,
    parameter int NS = rps_pkg::DIV_STAGES
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    localparam int PER = (QW + NS - 1) / NS;
    localparam int WW  = (DW > VW + QW) ? DW : VW + QW;

    logic [WW-1:0] rem_reg  [NS];
    logic [QW-1:0] quo_reg  [NS];
    logic [VW-1:0] dv_reg   [NS];
    logic [WW-1:0] rem_next [NS];
    logic [QW-1:0] quo_next [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        always_comb begin
            logic [WW-1:0] r;
            logic [QW-1:0] q;
            logic [VW-1:0] d;
            if (k == 0) begin
                r = WW'(dividend);
                q = '0;
                d = divisor;
            end else begin
                r = rem_reg[(k == 0) ? 0 : k - 1];
                q = quo_reg[(k == 0) ? 0 : k - 1];
                d = dv_reg[(k == 0) ? 0 : k - 1];
            end
            for (int j = 0; j < PER; j++) begin
                if (k * PER + j < QW) begin
                    if (r >= (WW'(d) << (QW - 1 - k * PER - j))) begin
                        r = r - (WW'(d) << (QW - 1 - k * PER - j));
                        q[QW - 1 - k * PER - j] = 1'b1;
                    end
                end
            end
            rem_next[k] = r;
            quo_next[k] = q;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                dv_reg[k]  <= (k == 0) ? divisor : dv_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign quotient = quo_reg[NS-1];

endmodule

/* sv/rps_score.sv */
// Weighted score: three products, sum, then divide by 1000 via reciprocal.
// Four register stages; depends on rps_pkg.
module rps_score (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [9:0]                  w_sig,
    input  logic [9:0]                  w_link,
    input  logic [9:0]                  w_age,
    input  logic [rps_pkg::TERM_W-1:0]  sig,
    input  logic [rps_pkg::TERM_W-1:0]  lq,
    input  logic [rps_pkg::TERM_W-1:0]  mat,
    output logic [rps_pkg::SCORE_W-1:0] score_reg
);

    logic [19:0] p_sig_reg, p_lq_reg, p_mat_reg;
    logic [21:0] sum_reg, sum2_reg;
    logic [34:0] prod_reg;
    logic [rps_pkg::SCORE_W-1:0] score_next;

    always_comb begin
        logic [12:0] q0;
        logic [21:0] rem;
        q0  = prod_reg[34:22];
        rem = sum2_reg - 22'(q0) * 22'(rps_pkg::TERM_FULL);
        score_next = (rem >= 22'(rps_pkg::TERM_FULL)) ? 12'(q0 + 13'd1) : q0[11:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_sig_reg <= 20'(w_sig) * 20'(sig);
            p_lq_reg  <= 20'(w_link) * 20'(lq);
            p_mat_reg <= 20'(w_age) * 20'(mat);
            sum_reg   <= 22'(p_sig_reg) + 22'(p_lq_reg) + 22'(p_mat_reg);
            prod_reg  <= 35'(sum_reg) * 35'(rps_pkg::DIV1K_RECIP);
            sum2_reg  <= sum_reg;
            score_reg <= score_next;
        end
    end

endmodule

/* sv/routing_parent_selector.sv */
// Throughput: one beat per cycle while the output is not stalled.
// The path is front stage, three divider stages, four score stages and the output
// register; the whole pipeline advances when the output is empty or taken.
// Reset (aresetn low, synchronous) clears all valid bits and loads register defaults.
// Depends on rps_pkg, rps_front, rps_div and rps_score.
module routing_parent_selector #(
    parameter int ETX_UNIT = rps_pkg::ETX_UNIT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // first_present, first_rssi, first_etx, first_age, first_rank, second_present,
    // second_rssi, second_etx, second_age, second_rank, preferred, 4 zero bits
    input  logic [119:0]              s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // chosen, first_score, second_score, 6 zero bits
    output logic [31:0]               m_tdata,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rps_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int DEPTH = rps_pkg::DIV_STAGES + 6;
    localparam int SB    = DEPTH - 2;
    localparam int DIVD  = rps_pkg::DIV_STAGES - 1;
    localparam logic [19:0] LQ_NUM = 20'(ETX_UNIT * rps_pkg::TERM_FULL);

    logic [9:0] w_sig_reg, w_link_reg, w_age_reg, margin_reg;
    logic [7:0] age_full_reg;
    logic       en;
    logic [DEPTH-1:0] vld_reg;
    rps_pkg::side_t   front_side;
    rps_pkg::divop_t  front_op;
    rps_pkg::side_t   sb_reg [SB];
    logic [9:0] lq1, lq2, mq1, mq2;
    logic [rps_pkg::SCORE_W-1:0] s1, s2;
    rps_pkg::out_beat_t out_reg, out_next;
    rps_pkg::reg_idx_t  ridx;

    assign ridx = rps_pkg::reg_idx_t'(paddr[4:2]);

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_sig_reg    <= 10'd400;
            w_link_reg   <= 10'd500;
            w_age_reg    <= 10'd100;
            age_full_reg <= 8'd15;
            margin_reg   <= 10'd20;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                rps_pkg::REG_WEIGHT_SIGNAL: w_sig_reg    <= pwdata[9:0];
                rps_pkg::REG_WEIGHT_LINK:   w_link_reg   <= pwdata[9:0];
                rps_pkg::REG_WEIGHT_MATURE: w_age_reg    <= pwdata[9:0];
                rps_pkg::REG_AGE_FULL:      age_full_reg <= pwdata[7:0];
                rps_pkg::REG_SWITCH_MARGIN: margin_reg   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            rps_pkg::REG_WEIGHT_SIGNAL: prdata = 32'(w_sig_reg);
            rps_pkg::REG_WEIGHT_LINK:   prdata = 32'(w_link_reg);
            rps_pkg::REG_WEIGHT_MATURE: prdata = 32'(w_age_reg);
            rps_pkg::REG_AGE_FULL:      prdata = 32'(age_full_reg);
            rps_pkg::REG_SWITCH_MARGIN: prdata = 32'(margin_reg);
            default:                    prdata = '0;
        endcase
    end

    // pipeline control
    assign en       = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[DEPTH-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    rps_front #(.ETX_UNIT(ETX_UNIT)) u_front (
        .aclk      (aclk),
        .en        (en),
        .beat      (rps_pkg::in_beat_t'(s_tdata)),
        .age_full  (age_full_reg),
        .side_reg  (front_side),
        .divop_reg (front_op)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= front_side;
            for (int i = 1; i < SB; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    rps_div #(.DW(20), .VW(16)) u_div_lq1 (
        .aclk(aclk), .en(en), .dividend(LQ_NUM), .divisor(front_op.etx1), .quotient(lq1)
    );
    rps_div #(.DW(20), .VW(16)) u_div_lq2 (
        .aclk(aclk), .en(en), .dividend(LQ_NUM), .divisor(front_op.etx2), .quotient(lq2)
    );
    rps_div #(.DW(rps_pkg::AGE_NUM_W), .VW(8)) u_div_age1 (
        .aclk(aclk), .en(en), .dividend(front_op.num1), .divisor(age_full_reg),
        .quotient(mq1)
    );
    rps_div #(.DW(rps_pkg::AGE_NUM_W), .VW(8)) u_div_age2 (
        .aclk(aclk), .en(en), .dividend(front_op.num2), .divisor(age_full_reg),
        .quotient(mq2)
    );

    rps_score u_score1 (
        .aclk(aclk), .en(en), .w_sig(w_sig_reg), .w_link(w_link_reg), .w_age(w_age_reg),
        .sig(sb_reg[DIVD].sig1), .lq(lq1),
        .mat(sb_reg[DIVD].full1 ? 10'(rps_pkg::TERM_FULL) : mq1),
        .score_reg(s1)
    );
    rps_score u_score2 (
        .aclk(aclk), .en(en), .w_sig(w_sig_reg), .w_link(w_link_reg), .w_age(w_age_reg),
        .sig(sb_reg[DIVD].sig2), .lq(lq2),
        .mat(sb_reg[DIVD].full2 ? 10'(rps_pkg::TERM_FULL) : mq2),
        .score_reg(s2)
    );

    always_comb begin
        rps_pkg::side_t sd;
        logic [12:0] s1m, s2m;
        rps_pkg::pick_t pick;
        sd  = sb_reg[SB-1];
        s1m = 13'(s1) + 13'(margin_reg);
        s2m = 13'(s2) + 13'(margin_reg);
        priority if (!sd.ok1) begin
            pick = sd.ok2 ? rps_pkg::PICK_SECOND : rps_pkg::PICK_NONE;
        end else if (!sd.ok2) begin
            pick = rps_pkg::PICK_FIRST;
        end else if (sd.pref == 2'(rps_pkg::PICK_FIRST)) begin
            pick = (13'(s2) > s1m) ? rps_pkg::PICK_SECOND : rps_pkg::PICK_FIRST;
        end else if (sd.pref == 2'(rps_pkg::PICK_SECOND)) begin
            pick = (13'(s1) > s2m) ? rps_pkg::PICK_FIRST : rps_pkg::PICK_SECOND;
        end else if (s1 == s2 && sd.cost1 != sd.cost2) begin
            pick = (sd.cost1 < sd.cost2) ? rps_pkg::PICK_FIRST : rps_pkg::PICK_SECOND;
        end else begin
            pick = (s1 > s2) ? rps_pkg::PICK_FIRST : rps_pkg::PICK_SECOND;
        end
        out_next.pad          = '0;
        out_next.chosen       = pick;
        out_next.first_score  = (sd.ok1 && sd.ok2) ? s1 : '0;
        out_next.second_score = (sd.ok1 && sd.ok2) ? s2 : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

endmodule

/* sv/rps_chk.sv */
// Port-level checker for routing_parent_selector, attached by bind.
// Depends on rps_pkg.
module rps_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad chosen code");

    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == 2'(rps_pkg::PICK_NONE) |-> m_tdata[25:2] == '0)
        else $error("scores present with no parent");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:2] <= 12'd3069 && m_tdata[25:14] <= 12'd3069)
        else $error("score out of range");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");

endmodule

bind routing_parent_selector rps_chk u_rps_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
